### rtl/rel_object_bitstream_encoder_core_macros.svh
// Assertion macros for the checker file of the encoder.
`ifndef REL_OBJECT_BITSTREAM_ENCODER_CORE_MACROS_SVH
`define REL_OBJECT_BITSTREAM_ENCODER_CORE_MACROS_SVH

// Concurrent assertion sampled on clk, disabled while rst_n is low.
`define ROBE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that a condition never holds.
`define ROBE_ASSERT_NEVER(label, expr, msg) \
    `ROBE_ASSERT(label, !(expr), msg)

`endif

### rtl/robe_pkg.sv
// Shared types, record codes and sizes of the relocatable-object bitstream encoder.
package robe_pkg;

    localparam int MAIN_W         = 100;  // longest bit string one item adds
    localparam int SEQ_W          = 108;  // carried bits plus one item's bits
    localparam int NBITS_W        = 7;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 16;
    localparam int FIFO_DEPTH_DEF = 2;

    localparam logic [1:0] KIND_SEG_BEGIN = 2'd0;
    localparam logic [1:0] KIND_PAIR      = 2'd1;
    localparam logic [1:0] KIND_SEG_END   = 2'd2;
    localparam logic [1:0] KIND_FINISH    = 2'd3;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_NO_PENDING = 2'd1;
    localparam logic [1:0] ERR_BAD_DIFF   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMON_END   = 1'd1;

    localparam logic [15:0] COMMON_END_RESET = 16'hF000;
    // Adding 0x1000 is the same as subtracting 0xF000 modulo 2^16.
    localparam logic [15:0] DATA_SIZE_BIAS   = 16'h1000;
    localparam logic [7:0]  COMMON_BASE      = 8'hF0;

    localparam logic [2:0] REC_SPECIAL    = 3'b100;
    localparam logic [3:0] SPC_NAME       = 4'd2;
    localparam logic [3:0] SPC_PROG_SIZE  = 4'd13;
    localparam logic [3:0] SPC_DATA_SIZE  = 4'd10;
    localparam logic [3:0] SPC_END_MODULE = 4'd14;
    localparam logic [3:0] SPC_END_FILE   = 4'd15;
    localparam logic [1:0] ADDR_ABS       = 2'b00;
    localparam logic [1:0] ADDR_PROGRAM   = 2'b01;
    localparam logic [1:0] ADDR_COMMON    = 2'b10;
    localparam logic [2:0] NAME_LEN       = 3'd5;
    localparam logic [39:0] SEG_NAME      = {8'h46, 8'h55, 8'h5A, 8'h49, 8'h58};

    localparam logic [6:0] TAIL_BITS = {REC_SPECIAL, SPC_END_FILE};
    localparam logic [2:0] TAIL_LEN  = 3'd7;

    typedef struct packed {
        logic [15:0] program_size;
        logic [15:0] common_end;
    } cfg_t;

    // One classified item: its bits MSB-aligned, their count, and what follows them.
    typedef struct packed {
        logic [MAIN_W-1:0]  bits;
        logic [NBITS_W-1:0] nbits;
        logic               pad;
        logic               tail;
        logic [1:0]         err;
    } work_t;

endpackage

### rtl/robe_in_if.sv
// Input item channel of the encoder.
interface robe_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] image_a_byte;
    logic [7:0] image_b_byte;

    modport source (output valid, output kind, output image_a_byte, output image_b_byte,
                    input ready);
    modport sink   (input valid, input kind, input image_a_byte, input image_b_byte,
                    output ready);
endinterface

### rtl/robe_out_if.sv
// Result channel of the encoder.
interface robe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] error_code;

    modport source (output valid, output out_byte, output last, output error_code,
                    input ready);
    modport sink   (input valid, input out_byte, input last, input error_code,
                    output ready);
endinterface

### rtl/robe_front.sv
// Front end: accepts items, tracks the held byte and the halt flag, builds work entries.
module robe_front
    import robe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    robe_in_if.sink    items,
    input  cfg_t       cfg,
    input  logic       fifo_full,
    output logic       push,
    output work_t      push_data
);

    logic [7:0]  pending_byte_reg, pending_byte_next;
    logic        pending_valid_reg, pending_valid_next;
    logic        halted_reg, halted_next;
    logic        accept;
    logic        diff_ok;
    logic [15:0] data_size;
    logic [24:0] end_module_rec;
    work_t       work;

    assign items.ready    = !fifo_full;
    assign accept         = items.valid && items.ready;
    assign push           = accept && !halted_reg;
    assign push_data      = work;
    assign diff_ok        = ({1'b0, items.image_b_byte} == ({1'b0, items.image_a_byte} + 9'd1));
    assign data_size      = cfg.common_end + DATA_SIZE_BIAS;
    assign end_module_rec = {REC_SPECIAL, SPC_END_MODULE, ADDR_ABS, 16'h0000};

    always_comb
    begin
        work               = '0;
        pending_byte_next  = pending_byte_reg;
        pending_valid_next = pending_valid_reg;
        halted_next        = halted_reg;
        case (items.kind)
            KIND_SEG_BEGIN:
            begin
                work.bits  = {REC_SPECIAL, SPC_NAME, NAME_LEN, SEG_NAME,
                              REC_SPECIAL, SPC_PROG_SIZE, ADDR_ABS, cfg.program_size,
                              REC_SPECIAL, SPC_DATA_SIZE, ADDR_COMMON, data_size};
                work.nbits = NBITS_W'(100);
            end
            KIND_PAIR:
            begin
                if (items.image_a_byte == items.image_b_byte)
                begin
                    if (pending_valid_reg)
                    begin
                        work.bits  = {1'b0, pending_byte_reg, 91'b0};
                        work.nbits = NBITS_W'(9);
                    end
                    pending_byte_next  = items.image_a_byte;
                    pending_valid_next = 1'b1;
                end
                else if (!diff_ok)
                begin
                    work.err    = ERR_BAD_DIFF;
                    halted_next = 1'b1;
                end
                else if (!pending_valid_reg)
                begin
                    work.err    = ERR_NO_PENDING;
                    halted_next = 1'b1;
                end
                else
                begin
                    work.bits  = {1'b1,
                                  (items.image_a_byte >= COMMON_BASE) ? ADDR_COMMON
                                                                      : ADDR_PROGRAM,
                                  items.image_a_byte, pending_byte_reg, 81'b0};
                    work.nbits = NBITS_W'(19);
                    pending_valid_next = 1'b0;
                end
            end
            KIND_SEG_END:
            begin
                if (pending_valid_reg)
                begin
                    work.bits  = {1'b0, pending_byte_reg, end_module_rec, 66'b0};
                    work.nbits = NBITS_W'(34);
                end
                else
                begin
                    work.bits  = {end_module_rec, 75'b0};
                    work.nbits = NBITS_W'(25);
                end
                work.pad           = 1'b1;
                work.tail          = 1'b1;
                pending_valid_next = 1'b0;
            end
            KIND_FINISH:
            begin
                work.pad = 1'b1;
            end
            default:
            begin
                work = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_byte_reg  <= '0;
            pending_valid_reg <= 1'b0;
            halted_reg        <= 1'b0;
        end
        else if (push)
        begin
            pending_byte_reg  <= pending_byte_next;
            pending_valid_reg <= pending_valid_next;
            halted_reg        <= halted_next;
        end
    end

endmodule

### rtl/robe_fifo.sv
// Short queue of work entries between the front and back ends.
module robe_fifo
    import robe_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    input  logic  pop,
    output work_t pop_data,
    output logic  full,
    output logic  empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    work_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/robe_back.sv
// Back end: merges work bits with the partial byte and sends one packed byte per cycle while the receiver is ready.
module robe_back
    import robe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fifo_empty,
    input  work_t       pop_data,
    output logic        pop,
    robe_out_if.source  results
);

    logic [7:0]         acc_reg, acc_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic [NBITS_W-1:0] rem_reg, rem_next;
    logic               tail_reg, tail_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;
    logic [1:0]         out_err_reg, out_err_next;

    logic               slot_free;
    logic               load;
    logic               emit;
    logic [7:0]         acc_al;
    logic [SEQ_W-1:0]   main_sh;
    logic [SEQ_W-1:0]   load_seq;
    logic [SEQ_W-1:0]   pad_mask;
    logic [SEQ_W-1:0]   eff_seq;
    logic [NBITS_W-1:0] load_len;
    logic [NBITS_W-1:0] len_up;
    logic [NBITS_W-1:0] eff_len;

    // Right-aligns the first r bits of an MSB-first byte.
    function automatic logic [7:0] align_right(input logic [7:0] top, input logic [2:0] r);
        return top >> (4'd8 - {1'b0, r});
    endfunction

    assign slot_free = !out_valid_reg || results.ready;
    assign load      = !busy_reg && !fifo_empty && slot_free;
    assign pop       = load;

    assign acc_al   = acc_reg << (4'd8 - {1'b0, cnt_reg});
    assign main_sh  = {pop_data.bits, 8'h00} >> cnt_reg;
    assign load_seq = {acc_al, {MAIN_W{1'b0}}} | main_sh;
    assign load_len = {{(NBITS_W-3){1'b0}}, cnt_reg} + pop_data.nbits;
    assign len_up   = (load_len + NBITS_W'(7)) & ~NBITS_W'(7);

    always_comb
    begin
        for (int i = 0; i < SEQ_W; i++)
        begin
            pad_mask[SEQ_W-1-i] = (NBITS_W'(i) >= load_len) && (NBITS_W'(i) < len_up);
        end
    end

    assign eff_seq = pop_data.pad ? (load_seq | pad_mask) : load_seq;
    assign eff_len = pop_data.pad ? len_up : load_len;

    always_comb
    begin
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        busy_next     = busy_reg;
        seq_next      = seq_reg;
        rem_next      = rem_reg;
        tail_next     = tail_reg;
        emit          = 1'b0;
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        out_err_next  = out_err_reg;
        if (busy_reg)
        begin
            if (slot_free)
            begin
                emit          = 1'b1;
                out_byte_next = seq_reg[SEQ_W-1 -: 8];
                out_last_next = (rem_reg < NBITS_W'(16));
                out_err_next  = ERR_NONE;
                seq_next      = seq_reg << 8;
                rem_next      = rem_reg - NBITS_W'(8);
                if (out_last_next)
                begin
                    busy_next = 1'b0;
                    if (tail_reg)
                    begin
                        acc_next = {1'b0, TAIL_BITS};
                        cnt_next = TAIL_LEN;
                    end
                    else
                    begin
                        acc_next = align_right(seq_reg[SEQ_W-9 -: 8], rem_reg[2:0]);
                        cnt_next = rem_reg[2:0];
                    end
                end
            end
        end
        else if (load)
        begin
            if (pop_data.err != ERR_NONE)
            begin
                emit          = 1'b1;
                out_byte_next = 8'h00;
                out_last_next = 1'b1;
                out_err_next  = pop_data.err;
            end
            else if (eff_len >= NBITS_W'(8))
            begin
                busy_next = 1'b1;
                seq_next  = eff_seq;
                rem_next  = eff_len;
                tail_next = pop_data.tail;
            end
            else if (pop_data.tail)
            begin
                acc_next = {1'b0, TAIL_BITS};
                cnt_next = TAIL_LEN;
            end
            else
            begin
                acc_next = align_right(eff_seq[SEQ_W-1 -: 8], eff_len[2:0]);
                cnt_next = eff_len[2:0];
            end
        end
    end

    assign out_valid_next = emit ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);

    assign results.valid      = out_valid_reg;
    assign results.out_byte   = out_byte_reg;
    assign results.last       = out_last_reg;
    assign results.error_code = out_err_reg;

    always_ff @(posedge clk)
    begin
        seq_reg      <= seq_next;
        rem_reg      <= rem_next;
        tail_reg     <= tail_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/rel_object_bitstream_encoder_core.sv
// A result beat passes through the queue, the back end's shift register and its output
// register; an error beat goes from the queue straight to the output register.
// The back end takes a new entry from the queue only once it has sent every byte of the last.
// The single byte lane of the back end limits throughput; the queue lets the front keep taking items.
// Reset (rst_n low, asynchronous) clears the bit accumulator, held byte, halt flag and queue;
// program_size resets to 0 and common_end to 0xF000.
module rel_object_bitstream_encoder_core
    import robe_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    robe_in_if.sink               items,
    robe_out_if.source            results,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers. The user must make writes arrive only while the block is idle;
    // the block does not enforce it. The front end reads them directly for a segment header.
    cfg_t  cfg_reg;

    // Front-to-queue and queue-to-back work entries.
    logic  push;
    work_t push_data;
    logic  pop;
    work_t pop_data;
    logic  fifo_full;
    logic  fifo_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.program_size <= '0;
            cfg_reg.common_end   <= COMMON_END_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PROGRAM_SIZE: cfg_reg.program_size <= cfg_data;
                CFG_COMMON_END:   cfg_reg.common_end   <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // The front end classifies each beat, keeps the held low byte and the
    // halt flag, and turns the item into a left-aligned bit string with flags
    // for padding and the end-file tail. Items after an error are dropped here.
    robe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cfg       (cfg_reg),
        .fifo_full (fifo_full),
        .push      (push),
        .push_data (push_data)
    );

    // A short queue decouples classification from bit packing so that a long
    // header on the output side does not stall the input side at once.
    robe_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    // The back end merges the partial byte with an entry as it loads it, then
    // hands out one packed byte per cycle while the receiver is ready, through its
    // output register, and marks the final byte of each item with last.
    robe_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .pop_data   (pop_data),
        .pop        (pop),
        .results    (results)
    );

endmodule

### rtl/robe_checker.sv
// Port-level checker for the encoder and its bind to the top level.
`include "rel_object_bitstream_encoder_core_macros.svh"

module robe_checker
    import robe_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_out_byte,
    input logic       res_last,
    input logic [1:0] res_error_code
);

    logic seen_err_reg;
    logic prev_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_err_reg  <= 1'b0;
            prev_last_reg <= 1'b1;
        end
        else if (res_valid && res_ready)
        begin
            seen_err_reg  <= seen_err_reg || (res_error_code != ERR_NONE);
            prev_last_reg <= res_last;
        end
    end

    `ROBE_ASSERT(a_stall_holds, res_valid && !res_ready |=> res_valid && $stable(res_out_byte) && $stable(res_last) && $stable(res_error_code), "result beat changed while stalled")
    `ROBE_ASSERT(a_error_shape, res_valid && res_error_code != ERR_NONE |-> res_out_byte == 8'h00 && res_last, "error beat must carry zero byte and last")
    `ROBE_ASSERT(a_error_alone, res_valid && res_error_code != ERR_NONE |-> prev_last_reg, "error beat inside an item's byte run")
    `ROBE_ASSERT_NEVER(a_quiet_after_error, seen_err_reg && res_valid, "result beat after an error")

endmodule

bind rel_object_bitstream_encoder_core robe_checker u_robe_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (results.valid),
    .res_ready      (results.ready),
    .res_out_byte   (results.out_byte),
    .res_last       (results.last),
    .res_error_code (results.error_code)
);

### verif/rel_stream_checker.sv
// Checker that predicts the encoder's result beats and compares them with the result channel.
module rel_stream_checker
    import robe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    robe_in_if                    items,
    robe_out_if                   results,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    owed_count,
    output int                    failures
);

    // Record fields of the object format, kept apart from the design's own package.
    localparam logic [2:0]  LINK_SPECIAL = 3'b100;
    localparam logic [3:0]  SR_NAME      = 4'd2;
    localparam logic [3:0]  SR_PROG_SIZE = 4'd13;
    localparam logic [3:0]  SR_DATA_SIZE = 4'd10;
    localparam logic [3:0]  SR_END_MOD   = 4'd14;
    localparam logic [3:0]  SR_END_FILE  = 4'd15;
    localparam logic [39:0] SEG_LABEL    = {8'h46, 8'h55, 8'h5A, 8'h49, 8'h58};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] code;
    } beat_t;

    logic [7:0]  acc;
    logic [2:0]  nbits;
    logic [7:0]  held_byte;
    logic        held_valid;
    logic        stopped;
    logic [15:0] prog_size;
    logic [15:0] common_top;
    logic [7:0]  item_bytes[$];
    beat_t       owed_beats[$];
    int          fail_tally = 0;

    function automatic void shift_in(input logic bitv);
        acc   = {acc[6:0], bitv};
        nbits = nbits + 3'd1;
        if (nbits == 3'd0)
        begin
            item_bytes.push_back(acc);
            acc = '0;
        end
    endfunction

    function automatic void shift_field(input logic [39:0] v, input int n);
        int i;
        for (i = n - 1; i >= 0; i--)
            shift_in(v[i]);
    endfunction

    function automatic void special_record(input logic [3:0] code);
        shift_field(40'(LINK_SPECIAL), 3);
        shift_field(40'(code), 4);
    endfunction

    function automatic void flush_held();
        if (held_valid)
        begin
            shift_in(1'b0);
            shift_field(40'(held_byte), 8);
        end
    endfunction

    function automatic void pad_to_byte();
        while (nbits != 3'd0)
            shift_in(1'b1);
    endfunction

    // Works out the beats that one accepted item causes and queues them.
    function automatic void encode_item(input logic [1:0] kind, input logic [7:0] a,
                                        input logic [7:0] b);
        logic [1:0] fault;
        beat_t      bt;
        int         i;
        item_bytes.delete();
        if (stopped)
            return;
        case (kind)
            KIND_SEG_BEGIN:
            begin
                special_record(SR_NAME);
                shift_field(40'd5, 3);
                shift_field(SEG_LABEL, 40);
                special_record(SR_PROG_SIZE);
                shift_field(40'd0, 2);
                shift_field(40'(prog_size), 16);
                special_record(SR_DATA_SIZE);
                shift_field(40'd2, 2);
                shift_field(40'(16'(common_top + 16'h1000)), 16);
            end
            KIND_PAIR:
            begin
                if (a == b)
                begin
                    flush_held();
                    held_byte  = a;
                    held_valid = 1'b1;
                end
                else
                begin
                    fault = ERR_NONE;
                    if ({1'b0, b} != {1'b0, a} + 9'd1)
                        fault = ERR_BAD_DIFF;
                    else if (!held_valid)
                        fault = ERR_NO_PENDING;
                    if (fault != ERR_NONE)
                    begin
                        stopped = 1'b1;
                        bt.data = 8'h00;
                        bt.last = 1'b1;
                        bt.code = fault;
                        owed_beats.push_back(bt);
                        return;
                    end
                    shift_in(1'b1);
                    shift_field((a >= 8'hF0) ? 40'd2 : 40'd1, 2);
                    shift_field(40'({a, held_byte}), 16);
                    held_valid = 1'b0;
                end
            end
            KIND_SEG_END:
            begin
                flush_held();
                held_valid = 1'b0;
                special_record(SR_END_MOD);
                shift_field(40'd0, 18);
                pad_to_byte();
                special_record(SR_END_FILE);
            end
            default:
                pad_to_byte();
        endcase
        for (i = 0; i < item_bytes.size(); i++)
        begin
            bt.data = item_bytes[i];
            bt.last = (i == item_bytes.size() - 1);
            bt.code = ERR_NONE;
            owed_beats.push_back(bt);
        end
    endfunction

    always @(posedge clk)
    begin
        beat_t want;
        if (!rst_n)
        begin
            acc        = '0;
            nbits      = '0;
            held_byte  = '0;
            held_valid = 1'b0;
            stopped    = 1'b0;
            prog_size  = 16'h0000;
            common_top = 16'hF000;
            owed_beats.delete();
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (owed_beats.size() == 0)
                begin
                    $error("unexpected result beat: out_byte %02h last %0d error_code %0d",
                           results.out_byte, results.last, results.error_code);
                    fail_tally++;
                end
                else
                begin
                    want = owed_beats.pop_front();
                    if (results.out_byte !== want.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.data, results.out_byte);
                        fail_tally++;
                    end
                    if (results.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, results.last);
                        fail_tally++;
                    end
                    if (results.error_code !== want.code)
                    begin
                        $error("error_code: expected %0d, got %0d", want.code,
                               results.error_code);
                        fail_tally++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PROGRAM_SIZE: prog_size  = cfg_data;
                    CFG_COMMON_END:   common_top = cfg_data;
                    default:          ;
                endcase
            end
            if (items.valid && items.ready)
                encode_item(items.kind, items.image_a_byte, items.image_b_byte);
        end
        owed_count <= owed_beats.size();
        failures   <= fail_tally;
    end

endmodule

### verif/testbench.sv
// Top of the encoder testbench: clock, reset, configuration and item stimulus, and the verdict.
module testbench;
    import robe_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    owed_count;
    int                    failures;

    // When set, neither the item sender nor the result receiver idles.
    logic steady;

    // Tracks whether the encoder holds a low byte, so that relocations are only
    // sent when they are legal until the deliberate fault at the very end.
    logic held;

    robe_in_if  item_ch ();
    robe_out_if result_ch ();

    rel_object_bitstream_encoder_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (item_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rel_stream_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (item_ch),
        .results    (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .owed_count (owed_count),
        .failures   (failures)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver stalls at random, with a chance of about 28 in a hundred, except in the steady stretch.
    always @(posedge clk)
    begin
        result_ch.ready <= steady || ($urandom_range(0, 99) >= 28);
    end

    // Safety net: the slowest legal run is far shorter than this.
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Presents one beat after a random number of idle cycles and returns at the
    // edge that accepts it. Valid stays high if the next beat follows at once.
    task automatic send_item(input logic [1:0] kind, input logic [7:0] a, input logic [7:0] b);
        while (!steady && $urandom_range(0, 99) < 28)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.kind         <= kind;
        item_ch.image_a_byte <= a;
        item_ch.image_b_byte <= b;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    // Framing items carry don't-care bytes; random ones toggle every bit.
    task automatic send_frame(input logic [1:0] kind);
        send_item(kind, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        if (kind == KIND_SEG_END)
            held = 1'b0;
    endtask

    task automatic send_data(input logic [7:0] a);
        send_item(KIND_PAIR, a, a);
        held = 1'b1;
    endtask

    task automatic send_reloc(input logic [7:0] a);
        send_item(KIND_PAIR, a, a + 8'd1);
        held = 1'b0;
    endtask

    // Stops sending until every predicted beat has arrived. Items that make no
    // beat may still sit in the encoder's queue, so a margin follows.
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (owed_count != 0);
        repeat (50) @(posedge clk);
    endtask

    // Writes both registers on consecutive edges; only called while idle.
    task automatic load_settings(input logic [15:0] prog_size, input logic [15:0] common_top);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PROGRAM_SIZE;
        cfg_data  <= prog_size;
        @(posedge clk);
        cfg_index <= CFG_COMMON_END;
        cfg_data  <= common_top;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed segments: many data bytes and relocations between
    // segment begins and ends, with stray framing and padding items mixed in.
    task automatic send_random();
        int         r;
        logic [7:0] a;
        r = $urandom_range(0, 99);
        if (r < 4)
            send_frame(KIND_SEG_BEGIN);
        else if (r < 8)
            send_frame(KIND_SEG_END);
        else if (r < 11)
            send_frame(KIND_FINISH);
        else if (held && $urandom_range(0, 99) < 40)
        begin
            // Bias some relocations onto the program/common boundary.
            case ($urandom_range(0, 5))
                0:       a = 8'hEF;
                1:       a = 8'hF0;
                2:       a = 8'hFE;
                default: a = 8'($urandom_range(0, 254));
            endcase
            send_reloc(a);
        end
        else
            send_data(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int         p;
        logic [7:0] a;
        logic [7:0] b;

        rst_n                = 1'b0;
        steady               = 1'b0;
        held                 = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        item_ch.valid        = 1'b0;
        item_ch.kind         = KIND_SEG_BEGIN;
        item_ch.image_a_byte = 8'h00;
        item_ch.image_b_byte = 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Header records with program_size and common_end at opposite extremes.
        load_settings(16'hFFFF, 16'h0000);

        // Directed segment: byte extremes, relocations on both sides of the
        // common boundary, a segment begin while a low byte is held, padding
        // with and without open bits, and a segment end with nothing held.
        send_frame(KIND_SEG_BEGIN);
        send_data(8'h00);
        send_reloc(8'h00);
        send_data(8'hFF);
        send_reloc(8'hF0);
        send_data(8'hAA);
        send_data(8'h55);
        send_reloc(8'hEF);
        send_data(8'h12);
        send_frame(KIND_SEG_BEGIN);
        send_reloc(8'hFE);
        send_data(8'h7F);
        send_frame(KIND_SEG_END);
        send_frame(KIND_FINISH);
        send_frame(KIND_FINISH);
        send_frame(KIND_SEG_END);
        send_data(8'h80);
        send_data(8'h80);
        send_frame(KIND_SEG_END);
        send_frame(KIND_FINISH);

        // Random phases, each under its own register settings. The encoder is
        // drained before every write; the second phase runs with no idling.
        for (p = 0; p < 4; p++)
        begin
            wait_drained();
            case (p)
                0:       load_settings(16'($urandom_range(0, 65535)),
                                       16'($urandom_range(0, 65535)));
                1:       load_settings(16'h0000, 16'hFFFF);
                2:       load_settings(16'hFFFF, 16'hEFFF);
                default: load_settings(16'($urandom_range(0, 65535)), COMMON_END_RESET);
            endcase
            steady <= (p == 1);
            send_frame(KIND_SEG_BEGIN);
            repeat (110) send_random();
        end
        wait_drained();
        steady <= 1'b0;

        // A fault halts the encoder for good, so it comes last: either a pair
        // whose bytes differ by something other than one, or a relocation with
        // no low byte held. Everything after it must be dropped silently.
        send_data(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0)
        begin
            a = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
            begin
                a = 8'hFF;
                b = 8'h00;
            end
            else
                b = a + 8'd2 + 8'($urandom_range(0, 253));
            send_item(KIND_PAIR, a, b);
        end
        else
        begin
            send_frame(KIND_SEG_END);
            send_reloc(8'($urandom_range(0, 254)));
        end
        send_frame(KIND_SEG_BEGIN);
        send_data(8'h3C);
        send_reloc(8'h3C);
        send_frame(KIND_SEG_END);
        send_frame(KIND_FINISH);
        wait_drained();

        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
